@@ hw/rtl/m3tu_pkg.sv @@
// Shared types and constants for the 3x3 transform unit.
// Holds command codes, controller states, command/status structs and the CORDIC table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package m3tu_pkg;

  typedef enum logic [2:0] {
    KIND_IDENTITY  = 3'd0,
    KIND_MULTIPLY  = 3'd1,
    KIND_ROT_X     = 3'd2,
    KIND_ROT_Y     = 3'd3,
    KIND_ROT_Z     = 3'd4,
    KIND_SCALE     = 3'd5,
    KIND_TRANSFORM = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CVT_LO,
    ST_CVT_HI,
    ST_CVT_SUM,
    ST_RED_INIT,
    ST_RED,
    ST_FOLD_WRAP,
    ST_FOLD_HALF,
    ST_CORDIC,
    ST_TRIG,
    ST_WAIT_OUT,
    ST_MAC
  } state_t;

  typedef struct packed {
    logic load;
    logic set_ident;
    logic cvt_lo;
    logic cvt_hi;
    logic cvt_sum;
    logic red_init;
    logic red_step;
    logic fold_wrap;
    logic fold_half;
    logic cordic_step;
    logic trig;
    logic mac_run;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic red_done;
    logic cordic_done;
    logic mac_done;
    logic out_busy;
  } status_t;

  localparam int WORD_W   = 32;
  localparam int PROD_W   = 64;
  localparam int ACC_W    = 66;
  localparam int CORDIC_W = 34;
  localparam int ATAN_LEN = 24;

  // 2*3.1415/360 in Q0.32, rounded
  localparam logic [26:0] DEG_TO_RAD_K = 27'd74959110;

  localparam logic signed [PROD_W-1:0] TWO_PI_Q32  = 64'sd26986075409;
  localparam logic signed [PROD_W-1:0] PI_Q32      = 64'sd13493037704;
  localparam logic signed [PROD_W-1:0] HALF_PI_Q32 = 64'sd6746518852;

  localparam logic signed [CORDIC_W-1:0] CORDIC_INV_GAIN = 34'sh026DD3B6A;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -66'sd2147483648;

  // arctangent of 2^-i in Q4.30, truncated
  function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [CORDIC_W-1:0] v;
    unique case (i)
      5'd0:    v = 34'sh03243F6A8;
      5'd1:    v = 34'sh01DAC6705;
      5'd2:    v = 34'sh00FADBAFC;
      5'd3:    v = 34'sh007F56EA6;
      5'd4:    v = 34'sh003FEAB76;
      5'd5:    v = 34'sh001FFD55B;
      5'd6:    v = 34'sh000FFFAAA;
      5'd7:    v = 34'sh0007FFF55;
      5'd8:    v = 34'sh0003FFFEA;
      5'd9:    v = 34'sh0001FFFFD;
      5'd10:   v = 34'sh0000FFFFF;
      5'd11:   v = 34'sh00007FFFF;
      5'd12:   v = 34'sh00003FFFF;
      5'd13:   v = 34'sh00001FFFF;
      5'd14:   v = 34'sh00000FFFF;
      5'd15:   v = 34'sh000007FFF;
      5'd16:   v = 34'sh000003FFF;
      5'd17:   v = 34'sh000001FFF;
      5'd18:   v = 34'sh000000FFF;
      5'd19:   v = 34'sh0000007FF;
      5'd20:   v = 34'sh0000003FF;
      5'd21:   v = 34'sh0000001FF;
      5'd22:   v = 34'sh0000000FF;
      5'd23:   v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/m3tu_channels.sv @@
// Valid/ready channel interfaces for the 3x3 transform unit.
// Input carries one command item; output carries one transformed vector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface m3tu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] operand_0;
  logic signed [31:0] operand_1;
  logic signed [31:0] operand_2;
  logic signed [31:0] operand_3;
  logic signed [31:0] operand_4;
  logic signed [31:0] operand_5;
  logic signed [31:0] operand_6;
  logic signed [31:0] operand_7;
  logic signed [31:0] operand_8;

  modport source (
    output valid, kind, operand_0, operand_1, operand_2, operand_3, operand_4,
           operand_5, operand_6, operand_7, operand_8,
    input  ready
  );
  modport sink (
    input  valid, kind, operand_0, operand_1, operand_2, operand_3, operand_4,
           operand_5, operand_6, operand_7, operand_8,
    output ready
  );
endinterface

interface m3tu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/m3tu_ctrl.sv @@
// Controller state machine for the 3x3 transform unit.
// Sequences angle conversion, CORDIC and the shared multiply-accumulate.
// Depends on m3tu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module m3tu_ctrl
  import m3tu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire kind_t   in_kind,
  input  wire status_t st,
  output logic         in_ready,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            KIND_MULTIPLY, KIND_SCALE:        state_nxt = ST_MAC;
            KIND_ROT_X, KIND_ROT_Y, KIND_ROT_Z: state_nxt = ST_CVT_LO;
            KIND_TRANSFORM:                   state_nxt = ST_WAIT_OUT;
            default:                          state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CVT_LO:    state_nxt = ST_CVT_HI;
      ST_CVT_HI:    state_nxt = ST_CVT_SUM;
      ST_CVT_SUM:   state_nxt = ST_RED_INIT;
      ST_RED_INIT:  state_nxt = ST_RED;
      ST_RED:       if (st.red_done) state_nxt = ST_FOLD_WRAP;
      ST_FOLD_WRAP: state_nxt = ST_FOLD_HALF;
      ST_FOLD_HALF: state_nxt = ST_CORDIC;
      ST_CORDIC:    if (st.cordic_done) state_nxt = ST_TRIG;
      ST_TRIG:      state_nxt = ST_MAC;
      ST_WAIT_OUT:  if (!st.out_busy) state_nxt = ST_MAC;
      ST_MAC:       if (st.mac_done) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state_r == ST_IDLE);
    cmd             = '0;
    cmd.load        = (state_r == ST_IDLE) && in_valid;
    cmd.set_ident   = cmd.load && (in_kind == KIND_IDENTITY);
    cmd.cvt_lo      = (state_r == ST_CVT_LO);
    cmd.cvt_hi      = (state_r == ST_CVT_HI);
    cmd.cvt_sum     = (state_r == ST_CVT_SUM);
    cmd.red_init    = (state_r == ST_RED_INIT);
    cmd.red_step    = (state_r == ST_RED);
    cmd.fold_wrap   = (state_r == ST_FOLD_WRAP);
    cmd.fold_half   = (state_r == ST_FOLD_HALF);
    cmd.cordic_step = (state_r == ST_CORDIC);
    cmd.trig        = (state_r == ST_TRIG);
    cmd.mac_run     = (state_r == ST_MAC);
    cmd.commit      = (state_r == ST_MAC) && st.mac_done;
  end

endmodule

`default_nettype wire

@@ hw/rtl/m3tu_dp.sv @@
// Datapath for the 3x3 transform unit: matrix banks, shared 32x32 multiplier,
// exact three-product accumulator, angle reduction and CORDIC rotator.
// Depends on m3tu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module m3tu_dp
  import m3tu_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cmd_t                     cmd,
  input  wire kind_t                    in_kind,
  input  wire logic signed [WORD_W-1:0] in_ops [9],
  input  wire logic                     out_ready,
  output status_t                       st,
  output logic                          out_valid,
  output logic signed [WORD_W-1:0]      out_x,
  output logic signed [WORD_W-1:0]      out_y,
  output logic signed [WORD_W-1:0]      out_z
);

  localparam int RED_N    = 26 - FRAC_BITS;
  localparam int RED_CW   = $clog2(RED_N + 1);
  localparam int CORDIC_N = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int TRIG_SH  = 30 - FRAC_BITS;
  localparam logic signed [WORD_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

  kind_t                      kind_r;
  logic signed [WORD_W-1:0]   op_r [9];
  logic                       ident_r;
  logic                       bank_r;
  logic signed [WORD_W-1:0]   mat0_r [9];
  logic signed [WORD_W-1:0]   mat1_r [9];

  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   racc_r;
  logic [RED_CW-1:0]          red_k_r;
  logic                       neg_r;
  logic signed [CORDIC_W-1:0] cx_r, cy_r, cz_r;
  logic [4:0]                 cord_i_r;
  logic signed [WORD_W-1:0]   cos_r, sin_r;

  logic [1:0]                 row_r, col_r, k_r;
  logic                       issue_done_r;
  logic                       p_vld_r, p_first_r, p_last_r;
  logic [1:0]                 p_row_r, p_col_r;
  logic signed [ACC_W-1:0]    acc_r, sum_r;
  logic                       fin_vld_r;
  logic [1:0]                 fin_row_r, fin_col_r;
  logic                       out_valid_r;
  logic signed [WORD_W-1:0]   ox_r, oy_r, oz_r;

  // operand selection
  logic [3:0]                 m_idx, s_idx, op_addr, w_idx;
  logic signed [WORD_W-1:0]   m_val, op_val, s_val;
  logic signed [WORD_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic                       issue;
  logic [1:0]                 col_last;
  logic signed [ACC_W-1:0]    acc_nxt, sum_sh;
  logic signed [WORD_W-1:0]   sat_val;
  logic signed [PROD_W-1:0]   red_cand, fold_r, fold_q;
  logic                       fold_neg;
  logic signed [CORDIC_W-1:0] xsh, ysh, atan_v, xf, yf, xf_sh, yf_sh;

  assign m_idx   = {1'b0, row_r, 1'b0} + {2'b00, row_r} + {2'b00, k_r};
  assign s_idx   = {1'b0, k_r, 1'b0} + {2'b00, k_r} + {2'b00, col_r};
  assign w_idx   = {1'b0, fin_row_r, 1'b0} + {2'b00, fin_row_r} + {2'b00, fin_col_r};
  assign op_addr = (kind_r == KIND_MULTIPLY) ? s_idx : {2'b00, k_r};
  assign op_val  = op_r[op_addr];

  always_comb begin
    if (ident_r) begin
      m_val = (row_r == k_r) ? ONE : '0;
    end else if (bank_r) begin
      m_val = mat1_r[m_idx];
    end else begin
      m_val = mat0_r[m_idx];
    end
  end

  always_comb begin
    s_val = '0;
    unique case (kind_r)
      KIND_MULTIPLY, KIND_TRANSFORM: s_val = op_val;
      KIND_SCALE:  s_val = (k_r == col_r) ? op_val : '0;
      KIND_ROT_X: begin
        unique case (s_idx)
          4'd0:    s_val = ONE;
          4'd4:    s_val = cos_r;
          4'd5:    s_val = -sin_r;
          4'd7:    s_val = sin_r;
          4'd8:    s_val = cos_r;
          default: s_val = '0;
        endcase
      end
      KIND_ROT_Y: begin
        unique case (s_idx)
          4'd0:    s_val = cos_r;
          4'd2:    s_val = sin_r;
          4'd4:    s_val = ONE;
          4'd6:    s_val = -sin_r;
          4'd8:    s_val = cos_r;
          default: s_val = '0;
        endcase
      end
      KIND_ROT_Z: begin
        unique case (s_idx)
          4'd0:    s_val = cos_r;
          4'd1:    s_val = -sin_r;
          4'd3:    s_val = sin_r;
          4'd4:    s_val = cos_r;
          4'd8:    s_val = ONE;
          default: s_val = '0;
        endcase
      end
      default: s_val = '0;
    endcase
  end

  // shared multiplier: angle scaling in a low 16-bit and a high 11-bit part, then matrix products
  always_comb begin
    priority if (cmd.cvt_lo) begin
      mul_a = op_r[0];
      mul_b = $signed({16'd0, DEG_TO_RAD_K[15:0]});
    end else if (cmd.cvt_hi) begin
      mul_a = op_r[0];
      mul_b = $signed({21'd0, DEG_TO_RAD_K[26:16]});
    end else begin
      mul_a = m_val;
      mul_b = s_val;
    end
  end
  assign mul_p = mul_a * mul_b;

  assign issue    = cmd.mac_run && !issue_done_r;
  assign col_last = (kind_r == KIND_TRANSFORM) ? 2'd0 : 2'd2;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      op_r   <= in_ops;
    end
    if (cmd.cvt_lo || cmd.cvt_hi || issue) begin
      prod_r <= mul_p;
    end
  end

  // issue counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_done_r <= 1'b1;
      p_vld_r      <= 1'b0;
    end else begin
      p_vld_r <= issue;
      if (cmd.load) begin
        issue_done_r <= 1'b0;
      end else if (issue && k_r == 2'd2 && col_r == col_last && row_r == 2'd2) begin
        issue_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= '0;
      col_r <= '0;
      k_r   <= '0;
    end else if (issue) begin
      if (k_r == 2'd2) begin
        k_r <= '0;
        if (col_r == col_last) begin
          col_r <= '0;
          row_r <= row_r + 2'd1;
        end else begin
          col_r <= col_r + 2'd1;
        end
      end else begin
        k_r <= k_r + 2'd1;
      end
    end
    p_first_r <= (k_r == 2'd0);
    p_last_r  <= (k_r == 2'd2);
    p_row_r   <= row_r;
    p_col_r   <= col_r;
  end

  // exact accumulate of three products
  assign acc_nxt = (p_first_r ? '0 : acc_r) + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else begin
      fin_vld_r <= p_vld_r && p_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_vld_r) begin
      acc_r <= acc_nxt;
      if (p_last_r) begin
        sum_r     <= acc_nxt;
        fin_row_r <= p_row_r;
        fin_col_r <= p_col_r;
      end
    end
  end

  // floor by the fraction width, then saturate
  assign sum_sh = sum_r >>> FRAC_BITS;
  always_comb begin
    priority if (sum_sh > SAT_MAX) begin
      sat_val = 32'sh7FFFFFFF;
    end else if (sum_sh < SAT_MIN) begin
      sat_val = 32'sh80000000;
    end else begin
      sat_val = sum_sh[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_vld_r && kind_r != KIND_TRANSFORM) begin
      if (bank_r) begin
        mat0_r[w_idx] <= sat_val;
      end else begin
        mat1_r[w_idx] <= sat_val;
      end
    end
    if (fin_vld_r && kind_r == KIND_TRANSFORM) begin
      unique case (fin_row_r)
        2'd0:    ox_r <= sat_val;
        2'd1:    oy_r <= sat_val;
        default: oz_r <= sat_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r     <= 1'b1;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.set_ident) begin
        ident_r <= 1'b1;
      end else if (cmd.commit && kind_r != KIND_TRANSFORM) begin
        ident_r <= 1'b0;
        bank_r  <= ~bank_r;
      end
      if (fin_vld_r && kind_r == KIND_TRANSFORM && fin_row_r == 2'd2) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // angle reduction: restoring remainder by 2*pi, then fold into [-pi/2, pi/2]
  assign red_cand = racc_r - (TWO_PI_Q32 <<< red_k_r);

  always_comb begin
    fold_neg = 1'b1;
    priority if (racc_r > HALF_PI_Q32) begin
      fold_r = racc_r - PI_Q32;
    end else if (racc_r < -HALF_PI_Q32) begin
      fold_r = racc_r + PI_Q32;
    end else begin
      fold_r   = racc_r;
      fold_neg = 1'b0;
    end
  end
  assign fold_q = fold_r >>> 2;

  always_ff @(posedge clk) begin
    if (cmd.cvt_hi) begin
      racc_r <= prod_r;
    end else if (cmd.cvt_sum) begin
      racc_r <= (racc_r + (prod_r <<< 16)) >>> FRAC_BITS;
    end else if (cmd.red_init) begin
      racc_r  <= racc_r[PROD_W-1] ? racc_r + (TWO_PI_Q32 <<< RED_N) : racc_r;
      red_k_r <= RED_CW'(RED_N);
    end else if (cmd.red_step) begin
      if (!red_cand[PROD_W-1]) begin
        racc_r <= red_cand;
      end
      red_k_r <= red_k_r - RED_CW'(1);
    end else if (cmd.fold_wrap) begin
      if (racc_r > PI_Q32) begin
        racc_r <= racc_r - TWO_PI_Q32;
      end
    end
  end

  // CORDIC rotation, one micro-rotation per cycle
  assign xsh    = cx_r >>> cord_i_r;
  assign ysh    = cy_r >>> cord_i_r;
  assign atan_v = atan_q30(cord_i_r);
  assign xf     = neg_r ? -cx_r : cx_r;
  assign yf     = neg_r ? -cy_r : cy_r;
  assign xf_sh  = xf >>> TRIG_SH;
  assign yf_sh  = yf >>> TRIG_SH;

  always_ff @(posedge clk) begin
    if (cmd.fold_half) begin
      neg_r    <= fold_neg;
      cz_r     <= fold_q[CORDIC_W-1:0];
      cx_r     <= CORDIC_INV_GAIN;
      cy_r     <= '0;
      cord_i_r <= '0;
    end else if (cmd.cordic_step) begin
      if (!cz_r[CORDIC_W-1]) begin
        cx_r <= cx_r - ysh;
        cy_r <= cy_r + xsh;
        cz_r <= cz_r - atan_v;
      end else begin
        cx_r <= cx_r + ysh;
        cy_r <= cy_r - xsh;
        cz_r <= cz_r + atan_v;
      end
      cord_i_r <= cord_i_r + 5'd1;
    end
    if (cmd.trig) begin
      cos_r <= xf_sh[WORD_W-1:0];
      sin_r <= yf_sh[WORD_W-1:0];
    end
  end

  always_comb begin
    st.red_done    = (red_k_r == '0);
    st.cordic_done = (cord_i_r == 5'(CORDIC_N - 1));
    st.mac_done    = issue_done_r && !p_vld_r && !fin_vld_r;
    st.out_busy    = out_valid_r;
  end

  assign out_valid = out_valid_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_z     = oz_r;

  a_commit_when_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (issue_done_r && !p_vld_r && !fin_vld_r))
    else $error("commit while products still in flight");

  a_commit_clears_ident: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && kind_r != KIND_TRANSFORM && !cmd.set_ident) |=> !ident_r)
    else $error("identity flag survived a matrix update");

  a_reduced_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.red_step && st.red_done) |=> (!racc_r[PROD_W-1] && racc_r < TWO_PI_Q32))
    else $error("angle not reduced into one turn");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_vld_r && kind_r == KIND_TRANSFORM) |-> !out_valid_r)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ hw/rtl/matrix3_transform_unit.sv @@
// Top level of the 3x3 transform unit: joins controller and datapath to the channels.
// Depends on m3tu_pkg, m3tu_channels, m3tu_ctrl and m3tu_dp.
`timescale 1ns / 1ps
`default_nettype none

// Holds a 3x3 Q(32-FRAC_BITS).FRAC_BITS matrix, identity after reset, and applies one
// command per input item; only transform returns a result. One item is worked at a
// time. All products go through one shared 32x32 multiplier, one product per cycle:
// identity and unused codes use none, transform 9, multiply and scale 27. Rotations
// first scale the angle, take one remainder step per bit and one CORDIC step per
// cycle, then use 27 products. A finished vector waits in the output register while
// the next item is taken; a second transform waits only until that vector has been
// taken.
module matrix3_transform_unit
  import m3tu_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  m3tu_in_if.sink         in_ch,
  m3tu_out_if.source      out_ch
);

  cmd_t                     cmd;
  status_t                  st;
  kind_t                    in_kind;
  logic signed [WORD_W-1:0] in_ops [9];

  assign in_kind   = kind_t'(in_ch.kind);
  assign in_ops[0] = in_ch.operand_0;
  assign in_ops[1] = in_ch.operand_1;
  assign in_ops[2] = in_ch.operand_2;
  assign in_ops[3] = in_ch.operand_3;
  assign in_ops[4] = in_ch.operand_4;
  assign in_ops[5] = in_ch.operand_5;
  assign in_ops[6] = in_ch.operand_6;
  assign in_ops[7] = in_ch.operand_7;
  assign in_ops[8] = in_ch.operand_8;

  m3tu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_kind),
    .st       (st),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  m3tu_dp #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_kind   (in_kind),
    .in_ops    (in_ops),
    .out_ready (out_ch.ready),
    .st        (st),
    .out_valid (out_ch.valid),
    .out_x     (out_ch.out_x),
    .out_y     (out_ch.out_y),
    .out_z     (out_ch.out_z)
  );

endmodule

`default_nettype wire
